### src/pngse_pkg.sv
package pngse_pkg;

	localparam int unsigned SIDE_W   = 13;
	localparam int unsigned RAW_W    = 27;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [SIDE_W-1:0] MAX_SIDE = 13'd4096;

	// stored block length; the block count math relies on 65536 = BLOCK_MAX + 1
	localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	// byte positions inside the file header run and the trailer run
	localparam logic [IDX_W-1:0] HDR_IHDR_TAG = 6'd12;
	localparam logic [IDX_W-1:0] HDR_IHDR_END = 6'd28;
	localparam logic [IDX_W-1:0] HDR_IDAT_TAG = 6'd37;
	localparam logic [IDX_W-1:0] HDR_LAST     = 6'd42;
	localparam logic [IDX_W-1:0] BLK_LAST     = 6'd4;
	localparam logic [IDX_W-1:0] TRL_ADLER_END = 6'd3;
	localparam logic [IDX_W-1:0] TRL_LAST     = 6'd19;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_BLK,
		PH_FILT,
		PH_DATA,
		PH_TRL
	} phase_t;

	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
		logic [RAW_W-1:0]  raw_total;
		logic [RAW_W-1:0]  idat_len;
	} dims_t;

	typedef struct packed {
		logic [7:0] data;
		logic       item_last;
		logic       file_end;
	} seq_out_t;

	function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0)
			r = 13'd1;
		else if (v > MAX_SIDE)
			r = MAX_SIDE;
		return r;
	endfunction

endpackage

### src/pngse_dims.sv
module pngse_dims (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pngse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pngse_pkg::SIDE_W-1:0]          cfg_data,
	output pngse_pkg::dims_t                      dims
);

	logic [pngse_pkg::SIDE_W-1:0] width_q, height_q;
	logic [pngse_pkg::SIDE_W-1:0] w_s1, h_s1;
	logic [pngse_pkg::RAW_W-1:0]  raw_s2;
	logic [10:0]                  q_s3;
	logic [16:0]                  sum_s3;
	logic [11:0]                  nblk_s4;
	logic [pngse_pkg::RAW_W-1:0]  idat_s5;

	logic [14:0]                  row_bytes;
	logic [pngse_pkg::RAW_W-1:0]  prod;
	logic                         wrap;
	logic [16:0]                  rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 13'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pngse_pkg::REG_WIDTH:  width_q  <= cfg_data;
				pngse_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		row_bytes = {w_s1, 2'b00} + 15'd1;
		prod      = 27'(h_s1) * 27'(row_bytes);
		wrap      = sum_s3 >= 17'(pngse_pkg::BLOCK_MAX);
		rem       = wrap ? sum_s3 - 17'(pngse_pkg::BLOCK_MAX) : sum_s3;
	end

	// registered stages s1 to s5 settle after a write, long before the header needs it
	always_ff @(posedge clk) begin
		w_s1    <= pngse_pkg::side_clamp(width_q);
		h_s1    <= pngse_pkg::side_clamp(height_q);
		raw_s2  <= prod;
		q_s3    <= raw_s2[26:16];
		sum_s3  <= 17'(raw_s2[26:16]) + 17'(raw_s2[15:0]);
		nblk_s4 <= 12'(q_s3) + 12'(wrap) + 12'(rem != '0);
		idat_s5 <= raw_s2 + 27'({nblk_s4, 2'b00}) + 27'(nblk_s4) + 27'd6;
	end

	assign dims.width     = w_s1;
	assign dims.height    = h_s1;
	assign dims.raw_total = raw_s2;
	assign dims.idat_len  = idat_s5;

endmodule

### src/pngse_core.sv
module pngse_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic                  emit,
	input  logic [7:0]            pix,
	input  pngse_pkg::dims_t      dims,
	output pngse_pkg::seq_out_t   seq
);

	pngse_pkg::phase_t phase_q, phase_d;

	logic [pngse_pkg::IDX_W-1:0] idx_q;
	logic [31:0]                 crc_q;
	logic [15:0]                 adl_lo_q, adl_hi_q;
	logic [pngse_pkg::RAW_W-1:0] raw_pos_q;
	logic [15:0]                 blk_rem_q;
	logic [14:0]                 row_rem_q;

	logic [7:0]                  b;
	logic                        phase_end, is_raw, crc_start, crc_run;
	logic                        at_end, final_blk;
	logic [pngse_pkg::RAW_W-1:0] left;
	logic [15:0]                 blk;
	logic [31:0]                 crc_next;
	logic [16:0]                 lo_sum, hi_sum;
	logic [15:0]                 lo_new, hi_new;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] x;
		x = c ^ {24'h0, d};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ pngse_pkg::CRC_POLY) : (x >> 1);
		return x;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [pngse_pkg::IDX_W-1:0] i,
		input pngse_pkg::dims_t d, input logic [31:0] c);
		logic [7:0] r;
		unique case (i)
			6'd0:  r = 8'd137;
			6'd1:  r = 8'h50;
			6'd2:  r = 8'h4E;
			6'd3:  r = 8'h47;
			6'd4:  r = 8'h0D;
			6'd5:  r = 8'h0A;
			6'd6:  r = 8'h1A;
			6'd7:  r = 8'h0A;
			6'd11: r = 8'h0D;
			6'd12: r = 8'h49;
			6'd13: r = 8'h48;
			6'd14: r = 8'h44;
			6'd15: r = 8'h52;
			6'd18: r = {3'b000, d.width[12:8]};
			6'd19: r = d.width[7:0];
			6'd22: r = {3'b000, d.height[12:8]};
			6'd23: r = d.height[7:0];
			6'd24: r = 8'h08;
			6'd25: r = 8'h06;
			6'd29: r = ~c[31:24];
			6'd30: r = ~c[23:16];
			6'd31: r = ~c[15:8];
			6'd32: r = ~c[7:0];
			6'd33: r = {5'b00000, d.idat_len[26:24]};
			6'd34: r = d.idat_len[23:16];
			6'd35: r = d.idat_len[15:8];
			6'd36: r = d.idat_len[7:0];
			6'd37: r = 8'h49;
			6'd38: r = 8'h44;
			6'd39: r = 8'h41;
			6'd40: r = 8'h54;
			6'd41: r = 8'h78;
			6'd42: r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] trl_byte(input logic [pngse_pkg::IDX_W-1:0] i,
		input logic [31:0] adl, input logic [31:0] c);
		logic [7:0] r;
		unique case (i)
			6'd0:  r = adl[31:24];
			6'd1:  r = adl[23:16];
			6'd2:  r = adl[15:8];
			6'd3:  r = adl[7:0];
			6'd4:  r = ~c[31:24];
			6'd5:  r = ~c[23:16];
			6'd6:  r = ~c[15:8];
			6'd7:  r = ~c[7:0];
			6'd12: r = 8'h49;
			6'd13: r = 8'h45;
			6'd14: r = 8'h4E;
			6'd15: r = 8'h44;
			6'd16: r = 8'hAE;
			6'd17: r = 8'h42;
			6'd18: r = 8'h60;
			6'd19: r = 8'h82;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	assign left      = dims.raw_total - raw_pos_q;
	assign final_blk = left[26:16] == '0;
	assign blk       = final_blk ? left[15:0] : pngse_pkg::BLOCK_MAX;
	assign at_end    = (raw_pos_q + 27'd1) == dims.raw_total;

	// outputs of the sequencer
	always_comb begin
		b         = 8'h00;
		phase_end = 1'b0;
		is_raw    = 1'b0;
		crc_start = 1'b0;
		crc_run   = 1'b0;
		seq.item_last = 1'b0;
		seq.file_end  = 1'b0;
		unique case (phase_q)
			pngse_pkg::PH_HDR: begin
				b         = hdr_byte(idx_q, dims, crc_q);
				phase_end = idx_q == pngse_pkg::HDR_LAST;
				crc_start = idx_q == pngse_pkg::HDR_IHDR_TAG ||
					idx_q == pngse_pkg::HDR_IDAT_TAG;
				crc_run   = (idx_q > pngse_pkg::HDR_IHDR_TAG &&
					idx_q <= pngse_pkg::HDR_IHDR_END) || idx_q > pngse_pkg::HDR_IDAT_TAG;
			end
			pngse_pkg::PH_BLK: begin
				unique case (idx_q)
					6'd0: b = {7'b0, final_blk};
					6'd1: b = blk[7:0];
					6'd2: b = blk[15:8];
					6'd3: b = ~blk[7:0];
					default: b = ~blk[15:8];
				endcase
				phase_end = idx_q == pngse_pkg::BLK_LAST;
				crc_run   = 1'b1;
			end
			pngse_pkg::PH_FILT: begin
				b         = 8'h00;
				phase_end = 1'b1;
				is_raw    = 1'b1;
				crc_run   = 1'b1;
			end
			pngse_pkg::PH_DATA: begin
				b         = pix;
				phase_end = 1'b1;
				is_raw    = 1'b1;
				crc_run   = 1'b1;
				seq.item_last = !at_end;
			end
			pngse_pkg::PH_TRL: begin
				b         = trl_byte(idx_q, {adl_hi_q, adl_lo_q}, crc_q);
				phase_end = idx_q == pngse_pkg::TRL_LAST;
				crc_run   = idx_q <= pngse_pkg::TRL_ADLER_END;
				seq.item_last = phase_end;
				seq.file_end  = phase_end;
			end
			default: ;
		endcase
		seq.data = b;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (emit && phase_end) begin
			unique case (phase_q)
				pngse_pkg::PH_HDR:
					phase_d = (blk_rem_q == '0) ? pngse_pkg::PH_BLK :
						(row_rem_q == '0) ? pngse_pkg::PH_FILT : pngse_pkg::PH_DATA;
				pngse_pkg::PH_BLK:
					phase_d = (row_rem_q == '0) ? pngse_pkg::PH_FILT : pngse_pkg::PH_DATA;
				pngse_pkg::PH_FILT:
					phase_d = (blk_rem_q == 16'd1) ? pngse_pkg::PH_BLK : pngse_pkg::PH_DATA;
				pngse_pkg::PH_DATA:
					phase_d = at_end ? pngse_pkg::PH_TRL :
						(blk_rem_q == 16'd1) ? pngse_pkg::PH_BLK :
						(row_rem_q == 15'd1) ? pngse_pkg::PH_FILT : pngse_pkg::PH_DATA;
				pngse_pkg::PH_TRL:
					phase_d = pngse_pkg::PH_HDR;
				default:
					phase_d = pngse_pkg::PH_HDR;
			endcase
		end
	end

	always_comb begin
		crc_next = crc_byte(crc_start ? 32'hFFFFFFFF : crc_q, b);
		lo_sum   = 17'(adl_lo_q) + 17'(b);
		lo_new   = (lo_sum >= pngse_pkg::ADLER_MOD) ?
			16'(lo_sum - pngse_pkg::ADLER_MOD) : lo_sum[15:0];
		hi_sum   = 17'(adl_hi_q) + 17'(lo_new);
		hi_new   = (hi_sum >= pngse_pkg::ADLER_MOD) ?
			16'(hi_sum - pngse_pkg::ADLER_MOD) : hi_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pngse_pkg::PH_HDR;
			idx_q     <= '0;
			crc_q     <= 32'hFFFFFFFF;
			adl_lo_q  <= 16'd1;
			adl_hi_q  <= '0;
			raw_pos_q <= '0;
			blk_rem_q <= '0;
			row_rem_q <= '0;
		end else if (restart) begin
			phase_q   <= pngse_pkg::PH_HDR;
			idx_q     <= '0;
			crc_q     <= 32'hFFFFFFFF;
			adl_lo_q  <= 16'd1;
			adl_hi_q  <= '0;
			raw_pos_q <= '0;
			blk_rem_q <= '0;
			row_rem_q <= '0;
		end else if (emit) begin
			phase_q <= phase_d;
			idx_q   <= phase_end ? '0 : idx_q + 6'd1;
			if (crc_start || crc_run)
				crc_q <= crc_next;
			if (is_raw) begin
				adl_lo_q  <= lo_new;
				adl_hi_q  <= hi_new;
				raw_pos_q <= raw_pos_q + 27'd1;
				blk_rem_q <= blk_rem_q - 16'd1;
			end
			if (phase_q == pngse_pkg::PH_BLK && phase_end)
				blk_rem_q <= blk;
			if (phase_q == pngse_pkg::PH_FILT)
				row_rem_q <= {dims.width, 2'b00};
			if (phase_q == pngse_pkg::PH_DATA)
				row_rem_q <= row_rem_q - 15'd1;
			if (phase_q == pngse_pkg::PH_TRL && phase_end) begin
				crc_q     <= 32'hFFFFFFFF;
				adl_lo_q  <= 16'd1;
				adl_hi_q  <= '0;
				raw_pos_q <= '0;
				blk_rem_q <= '0;
				row_rem_q <= '0;
			end
		end
	end

endmodule

### src/png_stored_deflate_encoder.sv
// Path: a pixel byte is held in pix_s1; its output beats go through the output register.
// Throughput: one output beat per cycle while a byte is held and the output is not stalled;
// a pixel byte gives one beat, plus 43 for the file header on the first byte of a
// frame, 5 per stored block header, 1 per row filter byte and 20 for the trailer
// after the last byte.
// Reset: arst_n clears the handshake state and the frame state; both sizes become 1.
module png_stored_deflate_encoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pngse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pngse_pkg::SIDE_W-1:0]          cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,   // [7:0] pixel_byte
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,   // [7:0] out_byte
	output logic                                  m_tlast,   // run_last
	output logic                                  m_tuser    // [0] file_end
);

	pngse_pkg::dims_t    dims;
	pngse_pkg::seq_out_t seq;

	logic       in_valid_s1;
	logic [7:0] pix_s1;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q, out_end_q;

	logic out_free, emit, item_done, accept;

	pngse_dims u_dims (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dims      (dims)
	);

	pngse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.emit    (emit),
		.pix     (pix_s1),
		.dims    (dims),
		.seq     (seq)
	);

	assign out_free  = !out_valid_q || m_tready;
	assign emit      = in_valid_s1 && out_free;
	assign item_done = emit && seq.item_last;
	assign s_tready  = !in_valid_s1 || item_done;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				in_valid_s1 <= 1'b1;
			else if (item_done)
				in_valid_s1 <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pix_s1 <= s_tdata;
		if (emit) begin
			out_byte_q <= seq.data;
			out_last_q <= seq.item_last;
			out_end_q  <= seq.file_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_end_q;

endmodule

### src/pngse_checker.sv
module pngse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
			$stable(m_tlast) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// the file end beat also closes its run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("file end beat without tlast");

	// an output beat is pending from the edge after a pixel byte is taken
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no output beat after input beat");

endmodule

bind png_stored_deflate_encoder pngse_checker u_pngse_checker (.*);
